// File: design/psvp_pkg.sv
// package for the planar shadow vertex projector: default sizes and register indexes
package psvp_pkg;

  // default number format, signed Q16.16
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z      = 3'd6;

endpackage

// File: design/planar_shadow_vertex_projector_core.sv
// planar shadow vertex projector: config registers, light precompute sequencer, vertex pipeline
//
// Projects each vertex along the light direction onto the ground plane, in signed fixed
// point (COORD_WIDTH bits, FRAC_BITS fraction bits), saturating every result. The vertex
// path is a five-stage pipeline that takes one vertex per clock unless the sequencer runs
// or a stall holds it; the last stage is the output register, and stalls on the master side
// only hold the stages that are full. The light terms (dot with the normal, the raise when
// it is below one half, and light divided by that dot) depend on configuration alone, so a
// sequencer works them out after reset and after every configuration write, using one
// shared multiplier and a one-bit-per-cycle restoring divider. While it runs s_axis_tready
// stays low. Configuration words are taken every cycle; the default format is Q16.16.
module planar_shadow_vertex_projector_core #(
  parameter int COORD_WIDTH = psvp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = psvp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [psvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]             cfg_data,
  // vertex stream in
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // fields from bit 0: vertex_x, vertex_y, vertex_z, zero fill
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                               s_axis_tlast,    // last_vertex
  // shadow stream out
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // fields from bit 0: shadow_x, shadow_y, shadow_z, zero fill
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic                               m_axis_tlast     // last_out
);

  localparam int CW     = COORD_WIDTH;
  localparam int DATA_W = ((3*CW+7)/8)*8;
  localparam int PW     = 2*CW;
  localparam int SW     = 2*CW+2;
  localparam int T_W    = ((CW > FRAC_BITS+1) ? CW : FRAC_BITS+1) + 1;
  localparam int XW     = 2*T_W+4;
  localparam int NW     = CW+FRAC_BITS;
  localparam int CNT_W  = $clog2(NW+1);

  localparam logic signed [CW-1:0] MAX_CW = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MIN_CW = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [XW-1:0] MAX_XW = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [XW-1:0] MIN_XW = {{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE_CW =
    (FRAC_BITS < CW-1) ? CW'(2**FRAC_BITS) : MAX_CW;
  localparam logic signed [T_W-1:0] HALF_T = T_W'(2**(FRAC_BITS-1));
  localparam logic [NW-1:0] QMAX_POS = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [NW-1:0] QMAX_NEG = NW'(1) << (CW-1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_DOT    = 3'd2;
  localparam logic [2:0] ST_DCHK   = 3'd3;
  localparam logic [2:0] ST_DDEC   = 3'd4;
  localparam logic [2:0] ST_RAISE  = 3'd5;
  localparam logic [2:0] ST_DIVSET = 3'd6;
  localparam logic [2:0] ST_DIV    = 3'd7;

  // saturate a wide signed value to the coordinate format
  function automatic logic signed [CW-1:0] sat_x(input logic signed [XW-1:0] a);
    logic signed [CW-1:0] r;
    if (a > MAX_XW) r = MAX_CW;
    else if (a < MIN_XW) r = MIN_CW;
    else r = a[CW-1:0];
    return r;
  endfunction

  function automatic logic signed [XW-1:0] sx_cw(input logic signed [CW-1:0] a);
    return {{(XW-CW){a[CW-1]}}, a};
  endfunction

  function automatic logic [CW-1:0] abs_cw(input logic signed [CW-1:0] a);
    return a[CW-1] ? (~a + 1'b1) : a;
  endfunction

  // configuration registers
  logic signed [CW-1:0] ground_x, ground_y, ground_z, plane_offset;
  logic signed [CW-1:0] light_x, light_y, light_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_x     <= '0;
      ground_y     <= '0;
      ground_z     <= ONE_CW;
      plane_offset <= '0;
      light_x      <= '0;
      light_y      <= '0;
      light_z      <= ONE_CW;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        psvp_pkg::REG_GROUND_X:     ground_x     <= cfg_data;
        psvp_pkg::REG_GROUND_Y:     ground_y     <= cfg_data;
        psvp_pkg::REG_GROUND_Z:     ground_z     <= cfg_data;
        psvp_pkg::REG_PLANE_OFFSET: plane_offset <= cfg_data;
        psvp_pkg::REG_LIGHT_X:      light_x      <= cfg_data;
        psvp_pkg::REG_LIGHT_Y:      light_y      <= cfg_data;
        psvp_pkg::REG_LIGHT_Z:      light_z      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // light precompute sequencer
  // ---------------------------------------------------------------------
  logic [2:0]             st;
  logic [CNT_W-1:0]       cnt;
  logic [1:0]             comp;
  logic                   raised;
  logic signed [CW-1:0]   l_eff [3];
  logic signed [CW-1:0]   p_arr [3];
  logic signed [XW-1:0]   acc;
  logic signed [CW-1:0]   d_reg;
  logic signed [T_W-1:0]  t_reg;
  logic signed [2*T_W-1:0] prod;
  logic [NW-1:0]          dvd;
  logic [CW:0]            rem;

  logic signed [T_W-1:0]  mop_a, mop_b;
  logic signed [CW-1:0]   g_sel, l_sel, l_prev;
  logic signed [XW-1:0]   prod_x;
  logic [CW:0]            rem_sh;
  logic [CW-1:0]          ud;
  logic                   q_bit;
  logic signed [CW-1:0]   div_res;
  logic signed [CW-1:0]   l_div;

  // operand pick for the shared multiplier
  always_comb begin
    case (cnt[1:0])
      2'd0:    begin g_sel = ground_x; l_sel = l_eff[0]; end
      2'd1:    begin g_sel = ground_y; l_sel = l_eff[1]; end
      2'd2:    begin g_sel = ground_z; l_sel = l_eff[2]; end
      default: begin g_sel = '0;       l_sel = '0;       end
    endcase
    case (cnt[1:0])
      2'd1:    l_prev = l_eff[0];
      2'd2:    l_prev = l_eff[1];
      2'd3:    l_prev = l_eff[2];
      default: l_prev = '0;
    endcase
    mop_b = {{(T_W-CW){g_sel[CW-1]}}, g_sel};
    mop_a = (st == ST_RAISE) ? t_reg : {{(T_W-CW){l_sel[CW-1]}}, l_sel};
    prod_x = {{(XW-2*T_W){prod[2*T_W-1]}}, prod};
  end

  // divider step and result fix-up
  always_comb begin
    l_div  = l_eff[comp];
    ud     = abs_cw(d_reg);
    rem_sh = {rem[CW-1:0], dvd[NW-1]};
    q_bit  = (rem_sh >= {1'b0, ud});
    if (d_reg == '0) begin
      if (l_div == '0) div_res = '0;
      else if (l_div[CW-1]) div_res = MIN_CW;
      else div_res = MAX_CW;
    end else if (l_div[CW-1] ^ d_reg[CW-1]) begin
      if (dvd > QMAX_NEG) div_res = MIN_CW;
      else div_res = CW'(~dvd + 1'b1);
    end else begin
      if (dvd > QMAX_POS) div_res = MAX_CW;
      else div_res = dvd[CW-1:0];
    end
  end

  // shared multiplier, one product a cycle
  always_ff @(posedge clk) begin
    prod <= mop_a * mop_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_START;
    end else if (cfg_valid) begin
      st <= ST_START;
    end else begin
      unique case (st)
        ST_IDLE: ;
        ST_START: begin
          l_eff[0] <= light_x;
          l_eff[1] <= light_y;
          l_eff[2] <= light_z;
          raised   <= 1'b0;
          acc      <= '0;
          cnt      <= '0;
          st       <= ST_DOT;
        end
        ST_DOT: begin
          if (cnt != '0) acc <= acc + prod_x;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(3)) st <= ST_DCHK;
        end
        ST_DCHK: begin
          d_reg <= sat_x(acc >>> FRAC_BITS);
          st    <= ST_DDEC;
        end
        ST_DDEC: begin
          cnt  <= '0;
          comp <= '0;
          if (!raised && ($signed({{(T_W-CW){d_reg[CW-1]}}, d_reg}) < HALF_T)) begin
            t_reg <= HALF_T - {{(T_W-CW){d_reg[CW-1]}}, d_reg};
            st    <= ST_RAISE;
          end else begin
            st <= ST_DIVSET;
          end
        end
        ST_RAISE: begin
          // raised light component = light + ((half - d) * normal >> frac)
          case (cnt[1:0])
            2'd1:    l_eff[0] <= sat_x(sx_cw(l_prev) + (prod_x >>> FRAC_BITS));
            2'd2:    l_eff[1] <= sat_x(sx_cw(l_prev) + (prod_x >>> FRAC_BITS));
            2'd3:    l_eff[2] <= sat_x(sx_cw(l_prev) + (prod_x >>> FRAC_BITS));
            default: ;
          endcase
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(3)) begin
            raised <= 1'b1;
            acc    <= '0;
            cnt    <= '0;
            st     <= ST_DOT;
          end
        end
        ST_DIVSET: begin
          dvd <= {abs_cw(l_div), {FRAC_BITS{1'b0}}};
          rem <= '0;
          cnt <= '0;
          st  <= ST_DIV;
        end
        ST_DIV: begin
          // one quotient bit a cycle, then store and move on
          if (cnt == CNT_W'(NW)) begin
            p_arr[comp] <= div_res;
            if (comp == 2'd2) st <= ST_IDLE;
            else begin
              comp <= comp + 1'b1;
              st   <= ST_DIVSET;
            end
          end else begin
            rem <= q_bit ? (rem_sh - {1'b0, ud}) : rem_sh;
            dvd <= {dvd[NW-2:0], q_bit};
            cnt <= cnt + 1'b1;
          end
        end
        default: st <= ST_START;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // vertex pipeline
  // ---------------------------------------------------------------------
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic signed [CW-1:0] vx1, vy1, vz1, vx2, vy2, vz2, vx3, vy3, vz3, vx4, vy4, vz4;
  logic                 l1, l2, l3, l4, l5;
  logic signed [PW-1:0] p1x, p1y, p1z;
  logic signed [SW-1:0] sum2;
  logic signed [CW-1:0] h3;
  logic signed [PW-1:0] q4x, q4y, q4z;
  logic signed [CW-1:0] ox5, oy5, oz5;
  logic signed [XW-1:0] h_wide;
  logic signed [CW-1:0] in_x, in_y, in_z;

  assign in_x = s_axis_tdata[CW-1:0];
  assign in_y = s_axis_tdata[2*CW-1:CW];
  assign in_z = s_axis_tdata[3*CW-1:2*CW];

  // stage ready chain, a stage moves when it is empty or the next one moves
  assign rdy5 = !v5 || m_axis_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1 && (st == ST_IDLE);

  assign h_wide = ($signed({{(XW-SW){sum2[SW-1]}}, sum2}) >>> FRAC_BITS)
                  + sx_cw(plane_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid && (st == ST_IDLE);
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    // products of vertex and normal
    if (rdy1) begin
      p1x <= in_x * ground_x;
      p1y <= in_y * ground_y;
      p1z <= in_z * ground_z;
      vx1 <= in_x;
      vy1 <= in_y;
      vz1 <= in_z;
      l1  <= s_axis_tlast;
    end
    // sum of the three products
    if (rdy2) begin
      sum2 <= {{2{p1x[PW-1]}}, p1x} + {{2{p1y[PW-1]}}, p1y} + {{2{p1z[PW-1]}}, p1z};
      vx2  <= vx1;
      vy2  <= vy1;
      vz2  <= vz1;
      l2   <= l1;
    end
    // height above the plane
    if (rdy3) begin
      h3  <= sat_x(h_wide);
      vx3 <= vx2;
      vy3 <= vy2;
      vz3 <= vz2;
      l3  <= l2;
    end
    // scaled light times height
    if (rdy4) begin
      q4x <= p_arr[0] * h3;
      q4y <= p_arr[1] * h3;
      q4z <= p_arr[2] * h3;
      vx4 <= vx3;
      vy4 <= vy3;
      vz4 <= vz3;
      l4  <= l3;
    end
    // subtract and saturate into the output register
    if (rdy5) begin
      ox5 <= sat_x(sx_cw(vx4) - ($signed({{(XW-PW){q4x[PW-1]}}, q4x}) >>> FRAC_BITS));
      oy5 <= sat_x(sx_cw(vy4) - ($signed({{(XW-PW){q4y[PW-1]}}, q4y}) >>> FRAC_BITS));
      oz5 <= sat_x(sx_cw(vz4) - ($signed({{(XW-PW){q4z[PW-1]}}, q4z}) >>> FRAC_BITS));
      l5  <= l4;
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = DATA_W'({oz5, oy5, ox5});
  assign m_axis_tlast  = l5;

endmodule

// File: test/shadow_projection_checker.sv
// checker for the shadow projector: watches the channels, predicts each shadow word and compares
`timescale 1ns / 1ps

module shadow_projection_checker (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_valid,
  input  logic                                          cfg_ready,
  input  logic [psvp_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [psvp_pkg::COORD_WIDTH_DEF-1:0]          cfg_data,
  input  logic                                          s_axis_tvalid,
  input  logic                                          s_axis_tready,
  // fields from bit 0: vertex_x, vertex_y, vertex_z
  input  logic [((3*psvp_pkg::COORD_WIDTH_DEF+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                          s_axis_tlast,
  input  logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // fields from bit 0: shadow_x, shadow_y, shadow_z
  input  logic [((3*psvp_pkg::COORD_WIDTH_DEF+7)/8)*8-1:0] m_axis_tdata,
  input  logic                                          m_axis_tlast,
  output int                                            pending,
  output int                                            failures
);

  localparam int CW = psvp_pkg::COORD_WIDTH_DEF;
  localparam int FB = psvp_pkg::FRAC_BITS_DEF;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [127:0]   wide_t;
  typedef struct packed {
    coord_t shadow_x;
    coord_t shadow_y;
    coord_t shadow_z;
    logic   last_out;
  } shadow_word_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // local copy of the plane and light registers, indexed by register code
  coord_t       plane_reg [0:psvp_pkg::REG_LIGHT_Z];
  shadow_word_t shadow_q [$];
  int           err_cnt = 0;

  initial begin
    pending  = 0;
    failures = 0;
  end

  // bring a wide value back into the coordinate range
  function automatic coord_t clamp_coord(wide_t a);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (CW-1)) - 1;
    lo = -hi - 1;
    if (a > hi) return COORD_MAX;
    if (a < lo) return COORD_MIN;
    return a[CW-1:0];
  endfunction

  // fixed point dot product, floor shift back to the format
  function automatic wide_t dot3(wide_t a0, wide_t a1, wide_t a2,
                                 wide_t b0, wide_t b1, wide_t b2);
    return (a0 * b0 + a1 * b1 + a2 * b2) >>> FB;
  endfunction

  // light component over the dot, toward zero; zero dot goes to the rail by sign
  function automatic coord_t div_light(wide_t num, wide_t den);
    if (den == 0) begin
      if (num == 0) return '0;
      return (num < 0) ? COORD_MIN : COORD_MAX;
    end
    return clamp_coord(num / den);
  endfunction

  // shadow of one vertex under the current plane and light
  function automatic shadow_word_t project_vertex(coord_t vx, coord_t vy, coord_t vz,
                                                  logic last);
    wide_t gx, gy, gz, lx, ly, lz, d, t, h, px, py, pz, half, one;
    shadow_word_t r;
    gx   = plane_reg[psvp_pkg::REG_GROUND_X];
    gy   = plane_reg[psvp_pkg::REG_GROUND_Y];
    gz   = plane_reg[psvp_pkg::REG_GROUND_Z];
    lx   = plane_reg[psvp_pkg::REG_LIGHT_X];
    ly   = plane_reg[psvp_pkg::REG_LIGHT_Y];
    lz   = plane_reg[psvp_pkg::REG_LIGHT_Z];
    half = wide_t'(1) <<< (FB-1);
    one  = wide_t'(1) <<< FB;
    d    = clamp_coord(dot3(lx, ly, lz, gx, gy, gz));
    // light too flat against the plane: push it along the normal, once
    if (d < half) begin
      t  = half - d;
      lx = clamp_coord(lx + ((t * gx) >>> FB));
      ly = clamp_coord(ly + ((t * gy) >>> FB));
      lz = clamp_coord(lz + ((t * gz) >>> FB));
      d  = clamp_coord(dot3(lx, ly, lz, gx, gy, gz));
    end
    px = div_light(lx * one, d);
    py = div_light(ly * one, d);
    pz = div_light(lz * one, d);
    h  = clamp_coord(dot3(vx, vy, vz, gx, gy, gz)
                     + wide_t'(plane_reg[psvp_pkg::REG_PLANE_OFFSET]));
    r.shadow_x = clamp_coord(wide_t'(vx) - ((px * h) >>> FB));
    r.shadow_y = clamp_coord(wide_t'(vy) - ((py * h) >>> FB));
    r.shadow_z = clamp_coord(wide_t'(vz) - ((pz * h) >>> FB));
    r.last_out = last;
    return r;
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    shadow_word_t want;
    shadow_word_t got;
    if (rst) begin
      plane_reg[psvp_pkg::REG_GROUND_X]     = '0;
      plane_reg[psvp_pkg::REG_GROUND_Y]     = '0;
      plane_reg[psvp_pkg::REG_GROUND_Z]     = coord_t'(1) <<< FB;
      plane_reg[psvp_pkg::REG_PLANE_OFFSET] = '0;
      plane_reg[psvp_pkg::REG_LIGHT_X]      = '0;
      plane_reg[psvp_pkg::REG_LIGHT_Y]      = '0;
      plane_reg[psvp_pkg::REG_LIGHT_Z]      = coord_t'(1) <<< FB;
      shadow_q.delete();
    end else begin
      // compare the outgoing word with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.shadow_x = m_axis_tdata[0 +: CW];
        got.shadow_y = m_axis_tdata[CW +: CW];
        got.shadow_z = m_axis_tdata[2*CW +: CW];
        got.last_out = m_axis_tlast;
        if (shadow_q.size() == 0) begin
          $error("shadow word with nothing expected: x %0d y %0d z %0d last %0b",
                 got.shadow_x, got.shadow_y, got.shadow_z, got.last_out);
          err_cnt++;
        end else begin
          want = shadow_q.pop_front();
          if (got.shadow_x !== want.shadow_x) begin
            $error("shadow_x: expected %0d, got %0d", want.shadow_x, got.shadow_x);
            err_cnt++;
          end
          if (got.shadow_y !== want.shadow_y) begin
            $error("shadow_y: expected %0d, got %0d", want.shadow_y, got.shadow_y);
            err_cnt++;
          end
          if (got.shadow_z !== want.shadow_z) begin
            $error("shadow_z: expected %0d, got %0d", want.shadow_z, got.shadow_z);
            err_cnt++;
          end
          if (got.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
            err_cnt++;
          end
        end
      end
      // predict each accepted vertex
      if (s_axis_tvalid && s_axis_tready)
        shadow_q.push_back(project_vertex(s_axis_tdata[0 +: CW], s_axis_tdata[CW +: CW],
                                          s_axis_tdata[2*CW +: CW], s_axis_tlast));
      // register writes, unused index ignored
      if (cfg_valid && cfg_ready && cfg_index <= psvp_pkg::REG_LIGHT_Z)
        plane_reg[cfg_index] = cfg_data;
    end
    pending  <= shadow_q.size();
    failures <= err_cnt;
  end

endmodule

// File: test/testbench.sv
// top of the shadow projector testbench: clock, reset, stimulus, stall patterns and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int CW = psvp_pkg::COORD_WIDTH_DEF;
  localparam int FB = psvp_pkg::FRAC_BITS_DEF;
  localparam int DW = ((3*CW+7)/8)*8;
  // drain time after the last expected word
  localparam int SETTLE = 10;
  localparam logic [psvp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t ONE_Q     = coord_t'(1) <<< FB;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [psvp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]                  cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [DW-1:0]                  s_axis_tdata = '0;   // vertex_x, vertex_y, vertex_z
  logic                           s_axis_tlast = 1'b0; // last_vertex
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [DW-1:0]                  m_axis_tdata;        // shadow_x, shadow_y, shadow_z
  logic                           m_axis_tlast;        // last_out

  int pending;
  int failures;
  int src_idle  = 0;
  int snk_stall = 0;

  planar_shadow_vertex_projector_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  shadow_projection_checker shadow_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pending       (pending),
    .failures      (failures)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver stalls
  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= snk_stall);

  function automatic coord_t fx(real r);
    return coord_t'($rtoi(r * (2.0 ** FB)));
  endfunction

  // uniform in [-span, span]
  function automatic coord_t rand_small(coord_t span);
    return coord_t'(int'($urandom_range(2 * span)) - int'(span));
  endfunction

  // mix of rails, zero, full range and modest values
  function automatic coord_t rand_coord();
    case ($urandom_range(9)) inside
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      [3:4]:   return coord_t'($urandom);
      default: return rand_small(fx(16.0));
    endcase
  endfunction

  // one vertex word, with random sender gaps in front
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                             input logic last);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [psvp_pkg::CFG_IDX_W-1:0] idx, input coord_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // new plane and light, written only once the pipeline has drained
  task automatic load_setting(input coord_t gx, input coord_t gy, input coord_t gz,
                              input coord_t offset,
                              input coord_t lx, input coord_t ly, input coord_t lz);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(psvp_pkg::REG_GROUND_X, gx);
    write_reg(psvp_pkg::REG_GROUND_Y, gy);
    write_reg(psvp_pkg::REG_GROUND_Z, gz);
    write_reg(psvp_pkg::REG_PLANE_OFFSET, offset);
    write_reg(REG_UNUSED, coord_t'($urandom));
    write_reg(psvp_pkg::REG_LIGHT_X, lx);
    write_reg(psvp_pkg::REG_LIGHT_Y, ly);
    write_reg(psvp_pkg::REG_LIGHT_Z, lz);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int     guard;
    int     axis;
    coord_t unit;
    coord_t vx, vy, vz;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset plane and light: straight down onto z = 0
    send_vertex('0, '0, '0, 1'b0);
    send_vertex(fx(1.5), fx(-2.25), fx(3.0), 1'b1);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);

    // slanted light, raised plane
    load_setting('0, '0, ONE_Q, fx(0.75), fx(0.5), fx(-0.25), ONE_Q);
    send_vertex(fx(2.0), fx(3.0), fx(4.0), 1'b0);
    send_vertex(fx(-7.5), fx(1.25), fx(-0.5), 1'b1);

    // light nearly parallel to the plane, raise applies
    load_setting('0, '0, ONE_Q, '0, ONE_Q, '0, fx(0.25));
    send_vertex(fx(1.0), fx(1.0), fx(2.0), 1'b0);
    send_vertex(fx(-3.0), fx(0.5), fx(-1.0), 1'b1);

    // light parallel to a y-up plane
    load_setting('0, ONE_Q, '0, fx(-1.5), '0, '0, -ONE_Q);
    send_vertex(fx(0.5), fx(2.0), fx(0.5), 1'b0);
    send_vertex(fx(10.0), fx(-4.0), fx(3.0), 1'b1);

    // zero normal: dot stays zero, division rails by sign
    load_setting('0, '0, '0, fx(2.0), ONE_Q, -ONE_Q, '0);
    send_vertex(fx(1.0), fx(2.0), fx(3.0), 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, '0, 1'b1);

    // short normal, dot still negative after the raise
    load_setting('0, fx(0.25), '0, fx(0.5), '0, fx(-4.0), '0);
    send_vertex(fx(1.0), fx(6.0), fx(-2.0), 1'b0);
    send_vertex(fx(-0.75), fx(-3.5), fx(9.0), 1'b1);

    // all registers at the top rail
    load_setting(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX);
    send_vertex(COORD_MAX, '0, COORD_MIN, 1'b0);
    send_vertex(fx(1.0), fx(-1.0), fx(0.5), 1'b1);

    // all registers at the bottom rail
    load_setting(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                 COORD_MIN);
    send_vertex(COORD_MIN, COORD_MAX, '0, 1'b0);
    send_vertex(fx(-2.0), fx(3.0), fx(0.25), 1'b1);

    // random phases, cycling through the idle patterns
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0:       begin src_idle = 0;  snk_stall = 0;  end
        1:       begin src_idle = 73; snk_stall = 0;  end
        2:       begin src_idle = 0;  snk_stall = 73; end
        default: begin src_idle = 9;  snk_stall = 9;  end
      endcase
      if (p % 3 == 0) begin
        load_setting(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord());
      end else begin
        // axis-aligned unit normal, modest light and offset
        axis = $urandom_range(2);
        unit = $urandom_range(1) ? ONE_Q : -ONE_Q;
        load_setting((axis == 0) ? unit : '0, (axis == 1) ? unit : '0,
                     (axis == 2) ? unit : '0, rand_small(fx(4.0)),
                     rand_small(fx(2.0)), rand_small(fx(2.0)), rand_small(fx(2.0)));
      end
      for (int n = 0; n < 125; n++) begin
        vx = ($urandom_range(3) == 0) ? rand_coord() : rand_small(fx(64.0));
        vy = ($urandom_range(3) == 0) ? rand_coord() : rand_small(fx(64.0));
        vz = ($urandom_range(3) == 0) ? rand_coord() : rand_small(fx(64.0));
        send_vertex(vx, vy, vz, $urandom_range(7) == 0);
      end
    end

    // drain and decide
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE * 2) @(posedge clk);
    if (pending != 0)
      $error("%0d expected shadow words never arrived", pending);
    if (failures == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
